// File: hdl/tccw_pkg.sv
package tccw_pkg;

    // Fixed field widths
    localparam int OP_W       = 1;
    localparam int CHAR_W     = 8;
    localparam int INDEX_W    = 11;
    localparam int WORD_W     = 16;
    localparam int CURSOR_W   = 11;
    localparam int COLOUR_W   = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = COLOUR_W;

    // Default screen geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUT  = 1'b0;
    localparam logic [OP_W-1:0] OP_READ = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = 1'b1;

    localparam logic [CHAR_W-1:0]   NEWLINE_CODE  = 8'd10;
    localparam logic [CHAR_W-1:0]   SPACE_CODE    = 8'd32;
    localparam logic [COLOUR_W-1:0] BG_RESET      = 4'd0;
    localparam logic [COLOUR_W-1:0] FG_RESET      = 4'd15;

    function automatic logic [WORD_W-1:0] make_cell(
        input logic [CHAR_W-1:0]   ch,
        input logic [COLOUR_W-1:0] fg,
        input logic [COLOUR_W-1:0] bg
    );
        return {bg, fg, ch};
    endfunction

    // Space, black on black
    localparam logic [WORD_W-1:0] BLANK_CELL = {4'd0, 4'd0, SPACE_CODE};

endpackage

// File: hdl/tccw_ifs.sv
interface tccw_cmd_if
    import tccw_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [CHAR_W-1:0]  char_code;
    logic [INDEX_W-1:0] cell_index;

    modport source (output valid, output op, output char_code, output cell_index,
                    input ready);
    modport sink   (input valid, input op, input char_code, input cell_index,
                    output ready);
endinterface

interface tccw_rsp_if
    import tccw_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [WORD_W-1:0]   cell_word;
    logic [CURSOR_W-1:0] cursor_position;

    modport source (output valid, output cell_word, output cursor_position,
                    input ready);
    modport sink   (input valid, input cell_word, input cursor_position,
                    output ready);
endinterface

// File: hdl/text_console_cell_writer.sv
// Channel   Dir  Beat payload                      Accepted when
// i_cmd     in   op, char_code, cell_index          valid && ready
// o_rsp     out  cell_word, cursor_position         valid && ready
// i_cfg_*   in   index, data (colour registers)     i_cfg_we
//
// Read and ordinary put: accepted beat, then S_EMIT, then the output register.
// Newline blanks the cells from the cursor to the end of its line (none at a
// line start); one cell is blanked per cycle through the single cell store
// write port and the cursor stepper. After reset the store is swept to blanks,
// one cell a cycle, with i_cmd.ready low. One item at a time; a new beat is taken
// while the previous result still sits in the output register.
module text_console_cell_writer
    import tccw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tccw_cmd_if.sink              i_cmd,
    tccw_rsp_if.source            o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);

    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_FILL  = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [ADDR_W-1:0]   r_cursor, n_cursor;
    logic [COL_W-1:0]    r_col, n_col;
    logic [COLOUR_W-1:0] r_bg, r_fg;
    logic                r_is_read, n_is_read;
    logic                r_rd_oob, n_rd_oob;
    logic [WORD_W-1:0]   r_rd_data;
    logic                r_out_valid;
    logic [WORD_W-1:0]   r_out_word;
    logic [CURSOR_W-1:0] r_out_cursor;

    logic [WORD_W-1:0]   mem [CELLS];

    logic                cmd_acc;
    logic                is_put, is_nl;
    logic                mem_we;
    logic [WORD_W-1:0]   mem_wd;
    logic [ADDR_W-1:0]   rd_addr;
    logic                out_load;

    // Cursor stepper shared by sweep, put and newline fill
    logic [ADDR_W-1:0]   adv_cursor;
    logic [COL_W-1:0]    adv_col;
    logic                at_eol;

    assign at_eol     = (r_col == LAST_COL);
    assign adv_col    = at_eol ? '0 : r_col + 1'b1;
    assign adv_cursor = (r_cursor == LAST_CELL) ? '0 : r_cursor + 1'b1;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign cmd_acc     = i_cmd.valid && i_cmd.ready;
    assign is_put      = (i_cmd.op == OP_PUT);
    assign is_nl       = (i_cmd.char_code == NEWLINE_CODE);
    assign rd_addr     = ADDR_W'(i_cmd.cell_index);
    assign out_load    = (r_state == S_EMIT) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        n_state   = r_state;
        n_cursor  = r_cursor;
        n_col     = r_col;
        n_is_read = r_is_read;
        n_rd_oob  = r_rd_oob;
        mem_we    = 1'b0;
        mem_wd    = BLANK_CELL;
        unique case (r_state)
            S_CLEAR: begin
                mem_we   = 1'b1;
                n_cursor = adv_cursor;
                n_col    = adv_col;
                if (r_cursor == LAST_CELL) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (cmd_acc) begin
                    n_is_read = !is_put;
                    n_rd_oob  = (32'(i_cmd.cell_index) >= CELLS);
                    n_state   = S_EMIT;
                    if (is_put && !is_nl) begin
                        mem_we   = 1'b1;
                        mem_wd   = make_cell(i_cmd.char_code, r_fg, r_bg);
                        n_cursor = adv_cursor;
                        n_col    = adv_col;
                    end else if (is_put && r_col != '0) begin
                        n_state = S_FILL;
                    end
                end
            end
            S_FILL: begin
                mem_we   = 1'b1;
                n_cursor = adv_cursor;
                n_col    = adv_col;
                if (at_eol) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_cursor] <= mem_wd;
        end
        if (cmd_acc) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cursor    <= '0;
            r_col       <= '0;
            r_is_read   <= 1'b0;
            r_rd_oob    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cursor  <= n_cursor;
            r_col     <= n_col;
            r_is_read <= n_is_read;
            r_rd_oob  <= n_rd_oob;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_word   <= (r_is_read && !r_rd_oob) ? r_rd_data : '0;
            r_out_cursor <= CURSOR_W'(r_cursor);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bg <= BG_RESET;
            r_fg <= FG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_BACKGROUND: r_bg <= i_cfg_data;
                REG_FOREGROUND: r_fg <= i_cfg_data;
            endcase
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.cell_word       = r_out_word;
    assign o_rsp.cursor_position = r_out_cursor;

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_cursor) < CELLS) && (32'(r_col) < COLUMNS))
        else $error("cursor or column out of range");

    a_fill_mid_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> (r_col != '0))
        else $error("newline fill running at a line start");

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_acc |=> (r_state == S_FILL || r_state == S_EMIT))
        else $error("accepted beat did not start work");

    a_fill_ends_at_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL && at_eol) |=> (r_col == '0 && r_state == S_EMIT))
        else $error("newline fill did not stop at the line start");

endmodule

// File: bench/tb_text_console_cell_writer.sv
module tb_text_console_cell_writer;
    timeunit 1ns;
    timeprecision 1ps;

    import tccw_pkg::*;

    localparam int CELLS        = DEF_COLUMNS * DEF_ROWS;
    localparam int INDEX_MAX    = (1 << INDEX_W) - 1;
    localparam int HOLD_CYCLES  = 200;
    // a newline may blank all but the first cell of a line, one cell a cycle
    localparam int DRAIN_CYCLES = DEF_COLUMNS + 20;

    typedef struct packed {
        logic [WORD_W-1:0]   word;
        logic [CURSOR_W-1:0] cursor;
    } t_cell_report;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tccw_cmd_if cmd_bus ();
    tccw_rsp_if rsp_bus ();

    text_console_cell_writer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_bus),
        .o_rsp       (rsp_bus),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // shadow of the console
    logic [WORD_W-1:0]   screen_model [CELLS];
    int                  cursor_model;
    logic [COLOUR_W-1:0] bg_model;
    logic [COLOUR_W-1:0] fg_model;

    t_cell_report awaited_reports [$];
    int           errors   = 0;
    bit           gaps_on  = 1'b1;
    bit           hold_req = 1'b0;

    always #6 i_clk = ~i_clk;

    function automatic void console_step(input logic [OP_W-1:0] op,
                                         input logic [CHAR_W-1:0] ch,
                                         input logic [INDEX_W-1:0] idx);
        t_cell_report rep;
        int           pos;
        rep.word = '0;
        if (op == OP_READ) begin
            if (idx < CELLS) rep.word = screen_model[idx];
        end else if (ch == NEWLINE_CODE) begin
            pos = cursor_model;
            while (pos % DEF_COLUMNS != 0 && pos < CELLS) begin
                screen_model[pos] = BLANK_CELL;
                pos++;
            end
            cursor_model = pos % CELLS;
        end else begin
            screen_model[cursor_model] = {bg_model, fg_model, ch};
            cursor_model = (cursor_model + 1) % CELLS;
        end
        rep.cursor = cursor_model[CURSOR_W-1:0];
        awaited_reports.push_back(rep);
    endfunction

    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                            input logic [INDEX_W-1:0] idx);
        while (gaps_on && $urandom_range(0, 99) < 29) begin
            cmd_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_bus.valid      <= 1'b1;
        cmd_bus.op         <= op;
        cmd_bus.char_code  <= ch;
        cmd_bus.cell_index <= idx;
        do @(posedge i_clk); while (!cmd_bus.ready);
        console_step(op, ch, idx);
    endtask

    task automatic wait_idle();
        cmd_bus.valid <= 1'b0;
        do @(posedge i_clk); while (awaited_reports.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_colours(input logic [COLOUR_W-1:0] bg,
                                 input logic [COLOUR_W-1:0] fg);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_BACKGROUND;
        cfg_data  <= bg;
        @(posedge i_clk);
        cfg_index <= REG_FOREGROUND;
        cfg_data  <= fg;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        bg_model = bg;
        fg_model = fg;
        @(posedge i_clk);
    endtask

    task automatic put_glyph();
        logic [CHAR_W-1:0] ch;
        do ch = CHAR_W'($urandom_range(0, 255)); while (ch == NEWLINE_CODE);
        send_cmd(OP_PUT, ch, INDEX_W'($urandom_range(0, INDEX_MAX)));
    endtask

    task automatic read_random_cell();
        logic [INDEX_W-1:0] idx;
        case ($urandom_range(0, 3))
            0:       idx = INDEX_W'($urandom_range(0, INDEX_MAX));
            1:       idx = INDEX_W'($urandom_range(CELLS, INDEX_MAX));
            // half the time just behind the cursor, where the writing happened
            default: idx = INDEX_W'((cursor_model + CELLS
                                     - $urandom_range(1, 2 * DEF_COLUMNS)) % CELLS);
        endcase
        send_cmd(OP_READ, CHAR_W'($urandom_range(0, 255)), idx);
    endtask

    task automatic random_item(input int read_pct, input int newline_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < read_pct)
            read_random_cell();
        else if (r < read_pct + newline_pct)
            send_cmd(OP_PUT, NEWLINE_CODE, INDEX_W'($urandom_range(0, INDEX_MAX)));
        else
            send_cmd(OP_PUT, CHAR_W'($urandom_range(0, 255)),
                     INDEX_W'($urandom_range(0, INDEX_MAX)));
    endtask

    task automatic test_reset_contents();
        send_cmd(OP_READ, 8'h00, 11'd0);
        send_cmd(OP_READ, 8'hFF, 11'd1);
        send_cmd(OP_READ, 8'h00, INDEX_W'(CELLS - 1));
        send_cmd(OP_READ, 8'hFF, INDEX_W'(CELLS));
        send_cmd(OP_READ, 8'h00, INDEX_W'(INDEX_MAX));
    endtask

    task automatic test_directed_puts();
        write_colours(4'd15, 4'd0);
        send_cmd(OP_PUT, NEWLINE_CODE, 11'd0);      // at line start: no effect
        send_cmd(OP_PUT, 8'h00, INDEX_W'(INDEX_MAX));
        send_cmd(OP_PUT, 8'hFF, 11'd0);
        send_cmd(OP_PUT, 8'h41, 11'd0);
        send_cmd(OP_PUT, NEWLINE_CODE, 11'd0);      // blanks to end of line
        send_cmd(OP_PUT, NEWLINE_CODE, 11'd0);
        send_cmd(OP_READ, 8'h00, 11'd0);
        send_cmd(OP_READ, 8'h00, 11'd1);
        send_cmd(OP_READ, 8'h00, 11'd2);
        send_cmd(OP_READ, 8'h00, 11'd3);
        send_cmd(OP_READ, 8'h00, INDEX_W'(DEF_COLUMNS - 1));
        send_cmd(OP_READ, 8'h00, INDEX_W'(DEF_COLUMNS));
        write_colours(4'd5, 4'd10);
        send_cmd(OP_PUT, 8'h55, 11'd0);
        send_cmd(OP_PUT, 8'hAA, 11'd0);
        send_cmd(OP_READ, 8'h00, INDEX_W'(DEF_COLUMNS));
        send_cmd(OP_READ, 8'h00, INDEX_W'(DEF_COLUMNS + 1));
    endtask

    task automatic test_line_wrap();
        gaps_on = 1'b1;
        write_colours(COLOUR_W'($urandom_range(0, 15)), COLOUR_W'($urandom_range(0, 15)));
        for (int pass = 0; pass < 2; pass++) begin
            // one short line at a time down to the last row
            while (cursor_model != CELLS - DEF_COLUMNS) begin
                put_glyph();
                send_cmd(OP_PUT, NEWLINE_CODE, INDEX_W'($urandom_range(0, INDEX_MAX)));
                if ($urandom_range(0, 3) == 0) read_random_cell();
            end
            if (pass == 0) begin
                // fill the last row: cursor wraps from the last cell to 0
                repeat (DEF_COLUMNS) put_glyph();
            end else begin
                repeat ($urandom_range(1, 40)) put_glyph();
                send_cmd(OP_PUT, NEWLINE_CODE, 11'd0);
            end
            repeat (3) send_cmd(OP_READ, CHAR_W'($urandom_range(0, 255)),
                                INDEX_W'($urandom_range(CELLS - DEF_COLUMNS, CELLS - 1)));
        end
    endtask

    task automatic test_random_traffic(input int count);
        gaps_on = 1'b1;
        for (int k = 0; k < count; k++) begin
            if (k % 50 == 0)
                write_colours(COLOUR_W'($urandom_range(0, 15)),
                              COLOUR_W'($urandom_range(0, 15)));
            random_item(35, 10);
        end
    endtask

    task automatic test_streaming();
        write_colours(4'd0, 4'd0);
        gaps_on = 1'b0;
        repeat (120) random_item(30, 8);
        wait_idle();
        gaps_on = 1'b1;
    endtask

    task automatic test_output_backpressure();
        gaps_on = 1'b1;
        write_colours(4'd15, 4'd15);
        hold_req = 1'b1;
        repeat (60) random_item(40, 10);
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin
        rsp_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                rsp_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            rsp_bus.ready <= !(gaps_on && $urandom_range(0, 99) < 29);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_cell_report want;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_reports.size() == 0) begin
                $display("%0t: unexpected beat, expected none, got word %h cursor %0d",
                         $time, rsp_bus.cell_word, rsp_bus.cursor_position);
                errors++;
            end else begin
                want = awaited_reports.pop_front();
                if (rsp_bus.cell_word !== want.word) begin
                    $display("%0t: cell_word expected %h, got %h",
                             $time, want.word, rsp_bus.cell_word);
                    errors++;
                end
                if (rsp_bus.cursor_position !== want.cursor) begin
                    $display("%0t: cursor_position expected %0d, got %0d",
                             $time, want.cursor, rsp_bus.cursor_position);
                    errors++;
                end
            end
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = REG_BACKGROUND;
        cfg_data           = '0;
        cmd_bus.valid      = 1'b0;
        cmd_bus.op         = OP_PUT;
        cmd_bus.char_code  = '0;
        cmd_bus.cell_index = '0;
        for (int c = 0; c < CELLS; c++) screen_model[c] = BLANK_CELL;
        cursor_model = 0;
        bg_model     = BG_RESET;
        fg_model     = FG_RESET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_contents();
        test_directed_puts();
        test_line_wrap();
        test_random_traffic(250);
        test_streaming();
        test_output_backpressure();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && awaited_reports.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
